/* design/ahs_pkg.sv */
`timescale 1ns / 1ps

package ahs_pkg;

	localparam int MAX_HARMONICS   = 32;
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;

	// Harmonic address and counter widths.
	localparam int HARM_AW = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
	localparam int HARM_CW = HARM_AW + 1;

	// Quarter-wave table geometry: positions per quadrant plus the closing point.
	localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
	localparam int QUARTER_ENTRIES = (1 << QUARTER_BITS) + 1;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;

	localparam int TIME_W   = 24;
	localparam int DIVIDEND_W = 41;
	localparam int Q16_W    = 17;
	localparam logic [Q16_W-1:0] ONE_Q16 = 17'h10000;
	localparam logic [TIME_W-1:0] ELAPSED_MAX = 24'hFFFFFF;

	localparam int SUM_W    = 33 + HARM_CW;
	localparam int SCALED_W = SUM_W + Q16_W + 1;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_START = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_INC   = 4'd0,
		REG_END_INC     = 4'd1,
		REG_ATTACK      = 4'd2,
		REG_DECAY       = 4'd3,
		REG_RELEASE     = 4'd4,
		REG_SUSTAIN     = 4'd5,
		REG_NOTE        = 4'd6,
		REG_HARM_COUNT  = 4'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                    start;
		logic [DIVIDEND_W-1:0]   dividend;
		logic [TIME_W-1:0]       divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic [DIVIDEND_W-1:0]   quotient;
	} div_rsp_t;

	// Quarter sine at table point j, evaluated at elaboration only.
	function automatic logic [14:0] quarter_sine(input int j);
		longint f;
		longint f2;
		longint f3;
		longint f5;
		longint s;
		longint v;
		begin
			f  = longint'(j) << (16 - QUARTER_BITS);
			f2 = (f * f) >> 16;
			f3 = (f2 * f) >> 16;
			f5 = (f3 * f2) >> 16;
			s  = (102943 * f + 4640 * f5 - 42047 * f3) >> 16;
			v  = (s * 32767 + 32768) >> 16;
			if (v > 32767) begin
				v = 32767;
			end
			quarter_sine = 15'(v);
		end
	endfunction

endpackage

/* design/ahs_if.sv */
`timescale 1ns / 1ps

interface ahs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [4:0]  harmonic_index;
	logic [15:0] start_amplitude;
	logic [15:0] end_amplitude;

	modport source (output valid, kind, harmonic_index, start_amplitude, end_amplitude,
		input ready);
	modport sink (input valid, kind, harmonic_index, start_amplitude, end_amplitude,
		output ready);
endinterface

interface ahs_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               note_active;

	modport source (output valid, sample, note_active, input ready);
	modport sink (input valid, sample, note_active, output ready);
endinterface

interface ahs_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ahs_pkg::CFG_INDEX_W-1:0]    index;
	logic [ahs_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* design/ahs_ram.sv */
`timescale 1ns / 1ps

module ahs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* design/ahs_div.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module ahs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  ahs_pkg::div_req_t req,
	output ahs_pkg::div_rsp_t rsp
);
	localparam int DW = ahs_pkg::DIVIDEND_W;
	localparam int VW = ahs_pkg::TIME_W;
	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    dvs_q;
	logic [VW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;
endmodule

/* design/ahs_sine.sv */
`timescale 1ns / 1ps

// Phase to signed sine sample through a quarter-wave constant table.
module ahs_sine (
	input  logic [ahs_pkg::PHASE_BITS-1:0] phase,
	output logic signed [15:0]             value
);
	localparam int QB = ahs_pkg::QUARTER_BITS;
	localparam int STB = ahs_pkg::SINE_TABLE_BITS;
	localparam int QE = ahs_pkg::QUARTER_ENTRIES;

	logic [14:0]    qtab [QE];
	logic [STB-1:0] idx;
	logic [QB:0]    point;
	logic [14:0]    mag;

	for (genvar g = 0; g < QE; g++) begin : g_tab
		assign qtab[g] = ahs_pkg::quarter_sine(g);
	end

	assign idx   = phase[ahs_pkg::PHASE_BITS-1 -: STB];
	assign point = idx[STB-2] ? ((QB+1)'(1 << QB) - {1'b0, idx[QB-1:0]})
		: {1'b0, idx[QB-1:0]};
	assign mag   = qtab[point];
	assign value = idx[STB-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
endmodule

/* design/additive_harmonic_synth_voice.sv */
`timescale 1ns / 1ps

// One additive synthesizer voice. Load and start words are handled in the idle state and leave
// the voice idle. A tick walks each harmonic in turn, up to the harmonic count capped at 32,
// and runs a serial division for the glide progress (skipped when the note length is zero) and
// one for the envelope (skipped in sustain and after the note). Each harmonic steps through
// ST_HRD, ST_HAMP0, ST_HAMP1 and ST_HACC: a read of the phase and amplitude memories, then
// a write of the advanced phase. Its sample word is held in an output register, so
// the next input word is taken while the sample waits.
module additive_harmonic_synth_voice (
	input logic       clk,
	input logic       arst_n,
	ahs_in_if.sink    in_ch,
	ahs_out_if.source out_ch,
	ahs_cfg_if.sink   cfg
);
	localparam int PB = ahs_pkg::PHASE_BITS;
	localparam int AW = ahs_pkg::HARM_AW;
	localparam int CW = ahs_pkg::HARM_CW;
	localparam int MH = ahs_pkg::MAX_HARMONICS;
	localparam int TW = ahs_pkg::TIME_W;
	localparam int QW = ahs_pkg::Q16_W;
	localparam int SW = ahs_pkg::SUM_W;
	localparam int XW = ahs_pkg::SCALED_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PROG, ST_INC0, ST_INC1, ST_HRD, ST_HAMP0, ST_HAMP1, ST_HACC,
		ST_ENV, ST_EWAIT, ST_SCALE, ST_OUT
	} state_t;

	state_t state_q;

	logic [30:0] start_inc_q, end_inc_q;
	logic [TW-1:0] attack_q, decay_q, release_q, note_q;
	logic [15:0] sustain_q;
	logic [5:0]  hcount_q;

	logic [TW-1:0] elapsed_q;
	logic [QW-1:0] prog_q;
	logic [47:0]   inc_prod_q;
	logic [PB-1:0] inc_q;
	logic [CW-1:0] count_q, idx_q;
	logic [MH-1:0] phase_vld_q, amp_vld_q;
	logic [PB-1:0] phase_q, step_q;
	logic [32:0]   amp_prod_q;
	logic [15:0]   end_amp_q, amp_q;
	logic signed [15:0] sine_q;
	logic signed [SW-1:0] sum_q;
	logic [QW-1:0] env_q;
	logic          env_sub_q;
	logic signed [XW-1:0] scaled_q;

	logic               out_valid_q;
	logic signed [15:0] sample_q;
	logic               active_q;

	ahs_pkg::div_req_t div_req_q;
	ahs_pkg::div_rsp_t div_rsp;

	logic [AW-1:0] haddr;
	logic          load_ok;
	logic          ram_re;
	logic [PB-1:0] phase_rd;
	logic [31:0]   amp_rd;
	logic [PB-1:0] phase_cur;
	logic [15:0]   start_amp_cur, end_amp_cur;
	logic signed [15:0] sine_val;
	logic [QW-1:0] one_minus_p;
	logic [48:0]   inc_sum;
	logic [33:0]   amp_sum;
	logic [7:0]    count_cap;
	logic [TW:0]   attack_decay, t_plus_r;
	logic signed [XW:0] rounded;
	logic signed [15:0] sample_sat;
	logic [TW-1:0] elapsed_next;
	logic          in_fire;
	logic          div_start;
	logic          out_load;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	assign haddr    = idx_q[AW-1:0];
	assign load_ok  = 32'(in_ch.harmonic_index) < MH;
	assign ram_re   = (state_q == ST_HRD);

	ahs_ram #(.WIDTH(PB), .DEPTH(MH)) u_phase_ram (
		.clk   (clk),
		.we    (state_q == ST_HACC),
		.waddr (haddr),
		.wdata (phase_q + step_q),
		.re    (ram_re),
		.raddr (haddr),
		.rdata (phase_rd)
	);

	ahs_ram #(.WIDTH(32), .DEPTH(MH)) u_amp_ram (
		.clk   (clk),
		.we    (in_fire && in_ch.kind == ahs_pkg::KIND_LOAD && load_ok),
		.waddr (AW'(in_ch.harmonic_index)),
		.wdata ({in_ch.start_amplitude, in_ch.end_amplitude}),
		.re    (ram_re),
		.raddr (haddr),
		.rdata (amp_rd)
	);

	ahs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.rsp    (div_rsp)
	);

	// Unwritten entries read zero: phase since reset or note start, amps since reset.
	assign phase_cur     = phase_vld_q[haddr] ? phase_rd : '0;
	assign start_amp_cur = amp_vld_q[haddr] ? amp_rd[31:16] : '0;
	assign end_amp_cur   = amp_vld_q[haddr] ? amp_rd[15:0] : '0;

	ahs_sine u_sine (
		.phase (phase_cur),
		.value (sine_val)
	);

	assign one_minus_p  = ahs_pkg::ONE_Q16 - prog_q;
	assign inc_sum      = {1'b0, inc_prod_q} + 49'(end_inc_q * prog_q);
	assign amp_sum      = {1'b0, amp_prod_q} + 34'(end_amp_q * prog_q);
	assign count_cap    = ({2'b0, hcount_q} < 8'(MH)) ? {2'b0, hcount_q} : 8'(MH);
	assign attack_decay = {1'b0, attack_q} + {1'b0, decay_q};
	assign t_plus_r     = {1'b0, elapsed_q} + {1'b0, release_q};
	assign elapsed_next = (elapsed_q == ahs_pkg::ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;

	// A division starts for the glide progress of a tick with a nonzero note length, and
	// for the envelope during attack, decay and release.
	assign div_start = (state_q == ST_IDLE && in_fire && in_ch.kind == ahs_pkg::KIND_TICK
			&& note_q != '0)
		|| (state_q == ST_ENV && (elapsed_q < attack_q || {1'b0, elapsed_q} < attack_decay
			|| (t_plus_r >= {1'b0, note_q} && elapsed_q < note_q)));

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	// Round half up after the 2^-32 scaling, then clamp to 16 bits.
	assign rounded = ($signed({scaled_q[XW-1], scaled_q})
		+ $signed((XW+1)'(33'h080000000))) >>> 32;
	always_comb begin
		if (rounded > (XW+1)'(32767)) begin
			sample_sat = 16'sd32767;
		end else if (rounded < -(XW+1)'(32768)) begin
			sample_sat = -16'sd32768;
		end else begin
			sample_sat = rounded[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_inc_q <= 31'd42852281;
			end_inc_q   <= 31'd42852281;
			attack_q    <= 24'd2205;
			decay_q     <= 24'd2205;
			release_q   <= 24'd2205;
			sustain_q   <= 16'd52429;
			note_q      <= '0;
			hcount_q    <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ahs_pkg::REG_START_INC:  start_inc_q <= cfg.data[30:0];
				ahs_pkg::REG_END_INC:    end_inc_q   <= cfg.data[30:0];
				ahs_pkg::REG_ATTACK:     attack_q    <= cfg.data[TW-1:0];
				ahs_pkg::REG_DECAY:      decay_q     <= cfg.data[TW-1:0];
				ahs_pkg::REG_RELEASE:    release_q   <= cfg.data[TW-1:0];
				ahs_pkg::REG_SUSTAIN:    sustain_q   <= cfg.data[15:0];
				ahs_pkg::REG_NOTE:       note_q      <= cfg.data[TW-1:0];
				ahs_pkg::REG_HARM_COUNT: hcount_q    <= cfg.data[5:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			elapsed_q   <= '0;
			phase_vld_q <= '0;
			amp_vld_q   <= '0;
			out_valid_q <= 1'b0;
			div_req_q   <= '0;
		end else begin
			div_req_q.start <= div_start;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_ch.kind)
							ahs_pkg::KIND_LOAD: begin
								if (load_ok) begin
									amp_vld_q[AW'(in_ch.harmonic_index)] <= 1'b1;
								end
							end
							ahs_pkg::KIND_START: begin
								elapsed_q   <= '0;
								phase_vld_q <= '0;
							end
							ahs_pkg::KIND_TICK: begin
								count_q <= CW'(count_cap);
								sum_q   <= '0;
								if (note_q == '0) begin
									prog_q  <= ahs_pkg::ONE_Q16;
									state_q <= ST_INC0;
								end else begin
									div_req_q.dividend <= 41'((elapsed_q < note_q ? elapsed_q
										: note_q)) << 16;
									div_req_q.divisor  <= note_q;
									state_q <= ST_PROG;
								end
							end
							default: ;
						endcase
					end
				end
				ST_PROG: begin
					if (div_rsp.done) begin
						prog_q  <= div_rsp.quotient[QW-1:0];
						state_q <= ST_INC0;
					end
				end
				ST_INC0: begin
					inc_prod_q <= start_inc_q * one_minus_p;
					state_q    <= ST_INC1;
				end
				ST_INC1: begin
					inc_q   <= {1'b0, inc_sum[46:16]} >> (32 - PB);
					idx_q   <= '0;
					state_q <= (count_q == '0) ? ST_ENV : ST_HRD;
				end
				ST_HRD: begin
					state_q <= ST_HAMP0;
				end
				ST_HAMP0: begin
					phase_q    <= phase_cur;
					sine_q     <= sine_val;
					amp_prod_q <= start_amp_cur * one_minus_p;
					end_amp_q  <= end_amp_cur;
					step_q     <= PB'(inc_q * (idx_q + 1'b1));
					state_q    <= ST_HAMP1;
				end
				ST_HAMP1: begin
					amp_q   <= amp_sum[31:16];
					state_q <= ST_HACC;
				end
				ST_HACC: begin
					sum_q <= sum_q + SW'($signed({1'b0, amp_q}) * sine_q);
					phase_vld_q[haddr] <= 1'b1;
					idx_q <= idx_q + 1'b1;
					state_q <= (idx_q + 1'b1 == count_q) ? ST_ENV : ST_HRD;
				end
				ST_ENV: begin
					if (elapsed_q < attack_q) begin
						div_req_q.dividend <= 41'(elapsed_q) << 16;
						div_req_q.divisor  <= attack_q;
						env_sub_q <= 1'b0;
						state_q   <= ST_EWAIT;
					end else if ({1'b0, elapsed_q} < attack_decay) begin
						div_req_q.dividend <= 41'((ahs_pkg::ONE_Q16 - {1'b0, sustain_q})
							* (elapsed_q - attack_q));
						div_req_q.divisor  <= decay_q;
						env_sub_q <= 1'b1;
						state_q   <= ST_EWAIT;
					end else if (t_plus_r < {1'b0, note_q}) begin
						env_q   <= {1'b0, sustain_q};
						state_q <= ST_SCALE;
					end else if (elapsed_q < note_q) begin
						div_req_q.dividend <= 41'(sustain_q * (note_q - elapsed_q));
						div_req_q.divisor  <= release_q;
						env_sub_q <= 1'b0;
						state_q   <= ST_EWAIT;
					end else begin
						env_q   <= '0;
						state_q <= ST_SCALE;
					end
				end
				ST_EWAIT: begin
					if (div_rsp.done) begin
						env_q   <= env_sub_q ? ahs_pkg::ONE_Q16 - div_rsp.quotient[QW-1:0]
							: div_rsp.quotient[QW-1:0];
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					scaled_q <= XW'(sum_q * $signed({1'b0, env_q}));
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						sample_q    <= sample_sat;
						active_q    <= elapsed_next < note_q;
						elapsed_q   <= elapsed_next;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.sample      = sample_q;
	assign out_ch.note_active = active_q;
endmodule
